// ===== rtl/core/wavp_pkg.sv =====
// Package for the WAV PCM16 mono parser: parse phases, status codes,
// chunk tags, size limits and the result record passed to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wavp_pkg;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_SKIP = 3'd2,
    PH_FMT  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_WAVE    = 3'd1,
    ST_BAD_FORMAT  = 3'd2,
    ST_DATA_NO_FMT = 3'd3,
    ST_NO_DATA     = 3'd4
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
  localparam logic [31:0] RIFF_LAST_BYTE = 32'd11;
  localparam logic [31:0] FMT_MIN_BYTES  = 32'd16;
  localparam logic [15:0] PCM_CODE       = 16'd1;
  localparam logic [15:0] MONO_CHANNELS  = 16'd1;
  localparam logic [15:0] PCM_BITS       = 16'd16;
  localparam logic [31:0] DEFAULT_RATE   = 32'd48000;

  localparam logic CFG_FILE_LENGTH   = 1'b0;
  localparam logic CFG_REQUIRED_RATE = 1'b1;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] sample;
    logic               is_sample;
    logic               final_result;
    status_t            status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/wavp_parser.sv =====
// Byte-level parse state for the WAV PCM16 mono parser. Holds offsets,
// chunk header and fmt fields; produces at most one result per beat.
// Depends on wavp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wavp_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      file_byte,
  input  wire logic [31:0]     file_length,
  input  wire logic [31:0]     required_rate,
  output wavp_pkg::result_t    res
);

  logic [31:0]      byte_offset,    byte_offset_next;
  wavp_pkg::phase_t parse_phase,    parse_phase_next;
  logic [31:0]      chunk_tag,      chunk_tag_next;
  logic [31:0]      chunk_length,   chunk_length_next;
  logic [31:0]      chunk_position, chunk_position_next;
  logic [33:0]      chunk_total,    chunk_total_next;
  logic             format_valid,   format_valid_next;
  logic [15:0]      format_code,    format_code_next;
  logic [15:0]      channel_count,  channel_count_next;
  logic [31:0]      rate_field,     rate_field_next;
  logic [15:0]      bits_field,     bits_field_next;
  logic [7:0]       low_byte,       low_byte_next;
  logic             finished,       finished_next;

  logic [31:0] bo_inc;
  logic [31:0] pos_inc;
  logic [31:0] tag_shift;
  logic [31:0] len_full;
  logic [33:0] fl_wide;
  logic [33:0] hdr_sum;
  logic        hdr_no_fit;
  logic        hdr_no_next;
  logic [33:0] hdr_total;
  logic        fmt_no_next;
  logic        skip_done;
  logic [31:0] fmt_idx;
  logic [15:0] bits_full;
  logic        fmt_good;
  logic        data_last;
  logic        err;
  wavp_pkg::status_t err_code;

  assign bo_inc    = byte_offset + 32'd1;
  assign pos_inc   = chunk_position + 32'd1;
  assign tag_shift = {chunk_tag[23:0], file_byte};
  assign len_full  = {file_byte, chunk_length[23:0]};
  assign fl_wide   = {2'b00, file_length};

  // Chunk start is byte_offset - 7 on the last header byte.
  assign hdr_sum     = {2'b00, byte_offset} + {2'b00, len_full};
  assign hdr_no_fit  = (hdr_sum + 34'd1) > fl_wide;
  assign hdr_no_next = (hdr_sum + 34'd9 + {33'd0, len_full[0]}) > fl_wide;
  assign hdr_total   = 34'd8 + {2'b00, len_full} + {33'd0, len_full[0]};

  // On fmt body byte 15 the chunk start is byte_offset - 23.
  assign fmt_no_next = ({2'b00, byte_offset} + chunk_total - 34'd15) > fl_wide;
  assign skip_done   = {2'b00, pos_inc} >= chunk_total;

  assign fmt_idx   = chunk_position - 32'd8;
  assign bits_full = {file_byte, bits_field[7:0]};
  assign fmt_good  = (format_code == wavp_pkg::PCM_CODE) &&
                     (channel_count == wavp_pkg::MONO_CHANNELS) &&
                     (rate_field == required_rate) &&
                     (bits_full == wavp_pkg::PCM_BITS);
  assign data_last = (chunk_position - 32'd7) == {chunk_length[31:1], 1'b0};

  always_comb begin
    byte_offset_next    = byte_offset;
    parse_phase_next    = parse_phase;
    chunk_tag_next      = chunk_tag;
    chunk_length_next   = chunk_length;
    chunk_position_next = chunk_position;
    chunk_total_next    = chunk_total;
    format_valid_next   = format_valid;
    format_code_next    = format_code;
    channel_count_next  = channel_count;
    rate_field_next     = rate_field;
    bits_field_next     = bits_field;
    low_byte_next       = low_byte;
    finished_next       = finished;
    res                 = '0;
    err                 = 1'b0;
    err_code            = wavp_pkg::ST_OK;

    if (!finished) begin
      unique case (parse_phase)
        wavp_pkg::PH_RIFF: begin
          chunk_tag_next = tag_shift;
          priority if (byte_offset == 32'd0 && file_length < wavp_pkg::MIN_FILE_BYTES) begin
            err      = 1'b1;
            err_code = wavp_pkg::ST_NOT_WAVE;
          end else if (byte_offset == 32'd3 && tag_shift != wavp_pkg::TAG_RIFF) begin
            err      = 1'b1;
            err_code = wavp_pkg::ST_NOT_WAVE;
          end else if (byte_offset == wavp_pkg::RIFF_LAST_BYTE) begin
            if (tag_shift != wavp_pkg::TAG_WAVE) begin
              err      = 1'b1;
              err_code = wavp_pkg::ST_NOT_WAVE;
            end else begin
              parse_phase_next    = wavp_pkg::PH_HDR;
              chunk_position_next = 32'd0;
              chunk_tag_next      = 32'd0;
            end
          end else begin
            // keep shifting in header bytes
          end
        end

        wavp_pkg::PH_HDR: begin
          chunk_position_next = pos_inc;
          if (chunk_position < 32'd4) begin
            chunk_tag_next = tag_shift;
          end else begin
            unique case (chunk_position[1:0])
              2'd0:    chunk_length_next[7:0]   = file_byte;
              2'd1:    chunk_length_next[15:8]  = file_byte;
              2'd2:    chunk_length_next[23:16] = file_byte;
              default: chunk_length_next[31:24] = file_byte;
            endcase
          end
          if (chunk_position == 32'd7) begin
            chunk_total_next = hdr_total;
            priority if (hdr_no_fit) begin
              err      = 1'b1;
              err_code = wavp_pkg::ST_NO_DATA;
            end else if (chunk_tag == wavp_pkg::TAG_FMT &&
                         len_full >= wavp_pkg::FMT_MIN_BYTES) begin
              parse_phase_next   = wavp_pkg::PH_FMT;
              format_code_next   = 16'd0;
              channel_count_next = 16'd0;
              rate_field_next    = 32'd0;
              bits_field_next    = 16'd0;
            end else if (chunk_tag == wavp_pkg::TAG_DATA) begin
              priority if (!format_valid) begin
                err      = 1'b1;
                err_code = wavp_pkg::ST_DATA_NO_FMT;
              end else if (len_full < 32'd2) begin
                err      = 1'b1;
                err_code = wavp_pkg::ST_NO_DATA;
              end else begin
                parse_phase_next = wavp_pkg::PH_DATA;
              end
            end else if (hdr_no_next) begin
              err      = 1'b1;
              err_code = wavp_pkg::ST_NO_DATA;
            end else if (len_full == 32'd0) begin
              // empty chunk: next header starts right away
              parse_phase_next    = wavp_pkg::PH_HDR;
              chunk_position_next = 32'd0;
              chunk_tag_next      = 32'd0;
              chunk_length_next   = 32'd0;
            end else begin
              parse_phase_next = wavp_pkg::PH_SKIP;
            end
          end
        end

        wavp_pkg::PH_DATA: begin
          chunk_position_next = pos_inc;
          if (!chunk_position[0]) begin
            low_byte_next = file_byte;
          end else begin
            res.hit       = 1'b1;
            res.sample    = {file_byte, low_byte};
            res.is_sample = 1'b1;
            res.status    = wavp_pkg::ST_OK;
            if (data_last) begin
              res.final_result = 1'b1;
              finished_next    = 1'b1;
            end
          end
        end

        wavp_pkg::PH_FMT, wavp_pkg::PH_SKIP: begin
          if (parse_phase == wavp_pkg::PH_FMT && fmt_idx[31:4] == 28'd0) begin
            unique case (fmt_idx[3:0])
              4'd0:    format_code_next[7:0]    = file_byte;
              4'd1:    format_code_next[15:8]   = file_byte;
              4'd2:    channel_count_next[7:0]  = file_byte;
              4'd3:    channel_count_next[15:8] = file_byte;
              4'd4:    rate_field_next[7:0]     = file_byte;
              4'd5:    rate_field_next[15:8]    = file_byte;
              4'd6:    rate_field_next[23:16]   = file_byte;
              4'd7:    rate_field_next[31:24]   = file_byte;
              4'd14:   bits_field_next[7:0]     = file_byte;
              4'd15:   bits_field_next[15:8]    = file_byte;
              default: ;
            endcase
            if (fmt_idx[3:0] == 4'd15) begin
              format_valid_next = fmt_good;
              priority if (!fmt_good) begin
                err      = 1'b1;
                err_code = wavp_pkg::ST_BAD_FORMAT;
              end else if (fmt_no_next) begin
                err      = 1'b1;
                err_code = wavp_pkg::ST_NO_DATA;
              end else begin
                // format good: advance through the rest of the chunk
              end
            end
          end
          if (!err) begin
            chunk_position_next = pos_inc;
            if (skip_done) begin
              parse_phase_next    = wavp_pkg::PH_HDR;
              chunk_position_next = 32'd0;
              chunk_tag_next      = 32'd0;
              chunk_length_next   = 32'd0;
            end
          end
        end

        default: ;
      endcase

      if (err) begin
        res.hit          = 1'b1;
        res.sample       = '0;
        res.is_sample    = 1'b0;
        res.final_result = 1'b1;
        res.status       = err_code;
        finished_next    = 1'b1;
      end
    end

    // Rearm once the whole file has gone by.
    byte_offset_next = bo_inc;
    if (bo_inc == 32'd0 || bo_inc >= file_length) begin
      byte_offset_next    = 32'd0;
      parse_phase_next    = wavp_pkg::PH_RIFF;
      chunk_tag_next      = 32'd0;
      chunk_length_next   = 32'd0;
      chunk_position_next = 32'd0;
      chunk_total_next    = 34'd0;
      format_valid_next   = 1'b0;
      format_code_next    = 16'd0;
      channel_count_next  = 16'd0;
      rate_field_next     = 32'd0;
      bits_field_next     = 16'd0;
      low_byte_next       = 8'd0;
      finished_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= 32'd0;
      parse_phase    <= wavp_pkg::PH_RIFF;
      chunk_tag      <= 32'd0;
      chunk_length   <= 32'd0;
      chunk_position <= 32'd0;
      chunk_total    <= 34'd0;
      format_valid   <= 1'b0;
      format_code    <= 16'd0;
      channel_count  <= 16'd0;
      rate_field     <= 32'd0;
      bits_field     <= 16'd0;
      low_byte       <= 8'd0;
      finished       <= 1'b0;
    end else if (step) begin
      byte_offset    <= byte_offset_next;
      parse_phase    <= parse_phase_next;
      chunk_tag      <= chunk_tag_next;
      chunk_length   <= chunk_length_next;
      chunk_position <= chunk_position_next;
      chunk_total    <= chunk_total_next;
      format_valid   <= format_valid_next;
      format_code    <= format_code_next;
      channel_count  <= channel_count_next;
      rate_field     <= rate_field_next;
      bits_field     <= bits_field_next;
      low_byte       <= low_byte_next;
      finished       <= finished_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wav_pcm16_mono_parser_unit.sv =====
// WAV PCM16 mono parser, top level: config registers, parser, result register.
// Latency: a result appears in the cycle after the byte beat that causes it.
// Throughput: one byte per cycle while file_stall is low; the parse state updates in the beat's own
// cycle and a single result register holds the output, refilled as it drains.
// Reset (rst, synchronous): parser to the RIFF header phase, file_length 0,
// required_rate 48000, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module wav_pcm16_mono_parser_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               file_valid,
  output logic                    file_stall,
  input  wire logic [7:0]         file_byte,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [15:0]      sample,
  output logic                    is_sample,
  output logic                    final_result,
  output logic [2:0]              status
);

  logic [31:0]       file_length;
  logic [31:0]       required_rate;
  logic              accept;
  wavp_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length   <= 32'd0;
      required_rate <= wavp_pkg::DEFAULT_RATE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wavp_pkg::CFG_FILE_LENGTH:   file_length   <= cfg_data;
        wavp_pkg::CFG_REQUIRED_RATE: required_rate <= cfg_data;
      endcase
    end
  end

  // Stall only while a result sits unread.
  assign file_stall = result_valid && result_stall;
  assign accept     = file_valid && !file_stall;

  wavp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .file_byte     (file_byte),
    .file_length   (file_length),
    .required_rate (required_rate),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= res.hit;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.hit) begin
      sample       <= res.sample;
      is_sample    <= res.is_sample;
      final_result <= res.final_result;
      status       <= res.status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wavp_checker.sv =====
// Port-level checks for the WAV PCM16 mono parser top level, with the bind
// that attaches them. Depends on wavp_pkg and wav_pcm16_mono_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

module wavp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               file_stall,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [15:0] sample,
  input wire logic               is_sample,
  input wire logic               final_result,
  input wire logic [2:0]         status
);

  // A held result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(sample) &&
      $stable(is_sample) && $stable(final_result) && $stable(status))
    else $error("result beat changed while stalled");

  a_sample_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_sample |-> status == wavp_pkg::ST_OK)
    else $error("sample beat with non-ok status");

  a_status_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_sample |-> final_result && sample == 16'sd0)
    else $error("status beat not final or carries a sample");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    file_stall |-> result_valid && result_stall)
    else $error("input stalled with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result pending right after reset");

endmodule

bind wav_pcm16_mono_parser_unit wavp_checker u_wavp_checker (.*);

`default_nettype wire
